FILE: hw/rtl/kmrg_pkg.sv
// ----------------------------------------------------------------------------
// kmrg_pkg
// Shared types and constants for the k-way key/payload merge.
// ----------------------------------------------------------------------------
package kmrg_pkg;

  localparam int KEY_W   = 32;
  localparam int RUN_W   = 4;
  localparam int REG_W   = 5;

  // stream payload: three fields packed, padded to whole bytes
  localparam int FIELDS_W = RUN_W + 2 * KEY_W;
  localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
  localparam int PAD_W    = TDATA_W - FIELDS_W;

  // APB register map
  localparam int          APB_ADDR_W      = 3;
  localparam int          APB_DATA_W      = 32;
  localparam logic [0:0]  REG_RUNS_IN_USE = 1'b0;
  localparam logic [REG_W-1:0] RUNS_RESET = 5'd16;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [RUN_W-1:0]        run_index;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] payload;
    logic                    exhausted;
  } kmrg_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic signed [KEY_W-1:0] out_payload;
    logic [RUN_W-1:0]        source_run;
    logic                    all_done;
  } kmrg_result_t;

endpackage

FILE: hw/rtl/kmrg_front.sv
// ----------------------------------------------------------------------------
// kmrg_front
// Accepts refill transactions, drops those for inactive runs and queues the
// rest for the merge engine.
// ----------------------------------------------------------------------------
module kmrg_front
  import kmrg_pkg::*;
#(
  parameter int NW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [NW-1:0]      n_eff_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]         s_axis_tuser,
  output logic               item_valid_o,
  output kmrg_item_t         item_o,
  input  logic               item_pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  kmrg_item_t       in_item;
  kmrg_item_t       q_item_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             accept, in_range, push, pop;

  assign in_item.run_index = s_axis_tdata[RUN_W-1:0];
  assign in_item.key       = s_axis_tdata[RUN_W+KEY_W-1:RUN_W];
  assign in_item.payload   = s_axis_tdata[RUN_W+2*KEY_W-1:RUN_W+KEY_W];
  assign in_item.exhausted = s_axis_tuser[0];

  assign s_axis_tready = (cnt_q != CNTW'(QUEUE_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  // refills for runs outside the active range never reach the engine
  assign in_range      = (32'(in_item.run_index) < 32'(n_eff_i));
  assign push          = accept && in_range;
  assign pop           = item_pop_i && (cnt_q != '0);

  assign item_valid_o = (cnt_q != '0);
  assign item_o       = q_item_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_item_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

FILE: hw/rtl/kmrg_min_tree.sv
// ----------------------------------------------------------------------------
// kmrg_min_tree
// Registered comparator tree: finds the smallest live head key, lowest run
// on ties. One register level per tree level.
// ----------------------------------------------------------------------------
module kmrg_min_tree
  import kmrg_pkg::*;
#(
  parameter int MAX_RUNS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [KEY_W-1:0] leaf_key_i  [MAX_RUNS],
  input  logic [MAX_RUNS-1:0]     leaf_live_i,
  output logic signed [KEY_W-1:0] root_key_o,
  output logic [$clog2(MAX_RUNS)-1:0] root_idx_o,
  output logic                    root_live_o
);

  localparam int IW = $clog2(MAX_RUNS);
  localparam int P  = 1 << IW;

  // heap numbering: 1..P-1 internal nodes, P..2P-1 leaves
  logic signed [KEY_W-1:0] vk [2*P];
  logic                    vl [2*P];
  logic [IW-1:0]           vi [2*P];

  logic signed [KEY_W-1:0] nk_q [1:P-1];
  logic                    nl_q [1:P-1];
  logic [IW-1:0]           ni_q [1:P-1];

  assign vk[0] = '0;
  assign vl[0] = 1'b0;
  assign vi[0] = '0;

  for (genvar l = 0; l < P; l++) begin : g_leaf
    assign vi[P+l] = IW'(l);
    if (l < MAX_RUNS) begin : g_real
      assign vk[P+l] = leaf_key_i[l];
      assign vl[P+l] = leaf_live_i[l];
    end else begin : g_pad
      assign vk[P+l] = '0;
      assign vl[P+l] = 1'b0;
    end
  end

  for (genvar j = 1; j < P; j++) begin : g_node
    logic pick_left;

    assign vk[j] = nk_q[j];
    assign vl[j] = nl_q[j];
    assign vi[j] = ni_q[j];

    // left subtree holds the lower runs, so it wins a tie
    assign pick_left = vl[2*j] && (!vl[2*j+1] || (vk[2*j] <= vk[2*j+1]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nl_q[j] <= 1'b0;
      end else begin
        nl_q[j] <= vl[2*j] || vl[2*j+1];
      end
    end

    always_ff @(posedge clk_i) begin
      nk_q[j] <= pick_left ? vk[2*j] : vk[2*j+1];
      ni_q[j] <= pick_left ? vi[2*j] : vi[2*j+1];
    end
  end

  assign root_key_o  = nk_q[1];
  assign root_idx_o  = ni_q[1];
  assign root_live_o = nl_q[1];

endmodule

FILE: hw/rtl/kmrg_back.sv
// ----------------------------------------------------------------------------
// kmrg_back
// Merge engine: applies queued refills to the run heads, waits for the
// comparator tree to settle and emits the smallest pair or the done marker.
// ----------------------------------------------------------------------------
module kmrg_back
  import kmrg_pkg::*;
#(
  parameter int MAX_RUNS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [MAX_RUNS-1:0] active_i,
  input  logic                item_valid_i,
  input  kmrg_item_t          item_i,
  output logic                item_pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output kmrg_result_t        res_o
);

  localparam int IW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(IW + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [MAX_RUNS-1:0]     live_q, live_d, fresh_q, fresh_d;
  logic signed [KEY_W-1:0] head_key_q [MAX_RUNS];
  logic signed [KEY_W-1:0] head_pay_q [MAX_RUNS];
  kmrg_result_t            out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic                    head_we, all_fresh;
  logic [IW-1:0]           wr_idx;
  logic signed [KEY_W-1:0] root_key;
  logic [IW-1:0]           root_idx;
  logic                    root_live;

  kmrg_min_tree #(
    .MAX_RUNS (MAX_RUNS)
  ) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .leaf_key_i  (head_key_q),
    .leaf_live_i (live_q & active_i),
    .root_key_o  (root_key),
    .root_idx_o  (root_idx),
    .root_live_o (root_live)
  );

  // the front only passes runs below the active count, so this fits
  assign wr_idx     = IW'(item_i.run_index);
  assign all_fresh  = &(fresh_q | ~active_i);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    live_d      = live_q;
    fresh_d     = fresh_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    head_we     = 1'b0;

    if (res_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i && !fresh_q[wr_idx]) begin
          fresh_d[wr_idx] = 1'b1;
          live_d[wr_idx]  = !item_i.exhausted;
          head_we         = !item_i.exhausted;
          cnt_d           = CW'(IW);
          state_d         = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (!all_fresh) begin
          state_d = ST_IDLE;
        end else if (cnt_q == CW'(1)) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || res_ready_i) begin
          out_valid_d = 1'b1;
          if (root_live) begin
            out_d.out_key     = root_key;
            out_d.out_payload = head_pay_q[root_idx];
            out_d.source_run  = RUN_W'(root_idx);
            out_d.all_done    = 1'b0;
            live_d[root_idx]  = 1'b0;
            fresh_d[root_idx] = 1'b0;
          end else begin
            // every active run exhausted: done marker, then rearm
            out_d   = '0;
            out_d.all_done = 1'b1;
            live_d  = '0;
            fresh_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      live_q      <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      live_q      <= live_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (head_we) begin
      head_key_q[wr_idx] <= item_i.key;
      head_pay_q[wr_idx] <= item_i.payload;
    end
  end

endmodule

FILE: hw/rtl/kway_merge_key_payload.sv
// ----------------------------------------------------------------------------
// kway_merge_key_payload
// K-way merge of sorted key/payload runs into one ascending stream.
// ----------------------------------------------------------------------------
// Input stream: each transaction refills the head of one run (run_index,
// key, payload in tdata; tuser[0] set means the run is exhausted). Refills
// for runs at or above runs_in_use (a value of zero counts as one), or for a
// run that already answered, are dropped. Output stream: once every active
// run holds a head or is exhausted, the smallest key (lowest run on ties)
// goes out with its payload and source_run; that run must then be refilled.
// When all active runs are exhausted a single transaction with tlast set and
// zero data ends the merge and the block rearms.
// Order: a refill passes through the 2-entry front queue and updates the
// heads as it leaves; the engine then waits in its settle state while the
// registered comparator tree settles, and the emit state loads the output
// register. The engine takes no further refill until that result is loaded.
// A refill that does not complete a round returns the engine to idle from
// the settle state.
// Reset clears all run state; runs_in_use returns to 16. A stalled output
// holds its register; the front queue keeps accepting until full.
// ----------------------------------------------------------------------------
module kway_merge_key_payload
  import kmrg_pkg::*;
#(
  parameter int MAX_RUNS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // refill stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,  // run_index[3:0], key[35:4], payload[67:36]
  input  logic [0:0]            s_axis_tuser,  // exhausted[0]
  // merged stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,  // out_key[31:0], out_payload[63:32],
                                               // source_run[67:64]
  output logic                  m_axis_tlast   // all_done
);

  localparam int NW = $clog2(MAX_RUNS + 1);

  logic [REG_W-1:0]    runs_q;
  logic [NW-1:0]       n_eff;
  logic [MAX_RUNS-1:0] active;
  logic                reg_wr;
  logic                item_valid, item_pop;
  kmrg_item_t          item;
  kmrg_result_t        res;

  // APB register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_RUNS_IN_USE);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_RUNS_IN_USE)
                  ? APB_DATA_W'(runs_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runs_q <= RUNS_RESET;
    end else if (reg_wr) begin
      runs_q <= pwdata[REG_W-1:0];
    end
  end

  // zero acts as one, anything above MAX_RUNS as MAX_RUNS
  always_comb begin
    if (runs_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(runs_q) > 32'(MAX_RUNS)) begin
      n_eff = NW'(MAX_RUNS);
    end else begin
      n_eff = NW'(runs_q);
    end
  end

  for (genvar i = 0; i < MAX_RUNS; i++) begin : g_active
    assign active[i] = (n_eff > NW'(i));
  end

  kmrg_front #(
    .NW (NW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .n_eff_i       (n_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  kmrg_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .active_i     (active),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res.source_run, res.out_payload, res.out_key};
  assign m_axis_tlast = res.all_done;

endmodule
